>>> rtl/text_console_char_engine_macros.svh
// Assertion macros used by the text console character engine RTL.
`ifndef TEXT_CONSOLE_CHAR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCCE_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCCE_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tcce_pkg.sv
// Package with types and constants of the text console character engine.
`timescale 1ns / 1ps

package tcce_pkg;

	localparam int ROWS_DEF        = 25;
	localparam int COLUMNS_DEF     = 80;
	localparam int TAB_STOP_DEF    = 8;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [15:0] BLANK_CELL  = 16'h0F20;
	localparam logic [7:0]  COLOR_RESET = 8'h0F;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [7:0] CH_BS       = 8'd8;
	localparam logic [7:0] CH_TAB      = 8'd9;
	localparam logic [7:0] CH_LF       = 8'd10;
	localparam logic [7:0] CH_FF       = 8'd12;
	localparam logic [7:0] CH_CR       = 8'd13;
	localparam logic [7:0] CH_PRINT_LO = 8'd32;
	localparam logic [7:0] CH_PRINT_HI = 8'd126;

	typedef struct packed {
		logic       operation;
		logic [7:0] char_byte;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
		logic [10:0] cursor_position;
		logic [7:0]  cell_char;
		logic [7:0]  cell_color;
		logic        scrolled;
	} out_item_t;

	typedef enum logic [2:0] {
		K_NOP,
		K_READ,
		K_BS,
		K_TAB,
		K_LF,
		K_FF,
		K_CR,
		K_PRINT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] char_byte;
		logic [7:0] color;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_FINISH,
		ST_IDLE,
		ST_RDATA
	} state_t;

endpackage

>>> rtl/tcce_front.sv
// Front end: start handshake, color register and byte classification.
`timescale 1ns / 1ps

module tcce_front
	import tcce_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  in_item_t   item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       queue_full,
	input  logic       init_busy,
	output logic       push,
	output cmd_t       cmd
);

	logic [7:0] text_color_q;
	cmd_kind_t  kind;

	assign cfg_ready = 1'b1;
	assign busy      = queue_full || init_busy;
	assign push      = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= COLOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			text_color_q <= cfg_data;
		end
	end

	always_comb begin
		kind = K_NOP;
		if (item.operation == OP_READ) begin
			kind = K_READ;
		end else begin
			case (item.char_byte)
				CH_BS: kind = K_BS;
				CH_TAB: kind = K_TAB;
				CH_LF: kind = K_LF;
				CH_FF: kind = K_FF;
				CH_CR: kind = K_CR;
				default: begin
					if (item.char_byte >= CH_PRINT_LO && item.char_byte <= CH_PRINT_HI) begin
						kind = K_PRINT;
					end else begin
						kind = K_NOP;
					end
				end
			endcase
		end
	end

	always_comb begin
		cmd.kind      = kind;
		cmd.char_byte = item.char_byte;
		cmd.color     = text_color_q;
		cmd.read_row  = item.read_row;
		cmd.read_col  = item.read_col;
	end

endmodule

>>> rtl/tcce_queue.sv
// Short command queue between the front end and the execution unit.
`timescale 1ns / 1ps

module tcce_queue
	import tcce_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic valid,
	output logic full,
	output cmd_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	cmd_t          slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] cnt_q;

	assign valid = (cnt_q != '0);
	assign full  = (cnt_q == NW'(DEPTH));
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> rtl/tcce_back.sv
// Execution unit: screen memory, cursor, scroll and clear sweeps, results.
`timescale 1ns / 1ps

module tcce_back
	import tcce_pkg::*;
#(
	parameter int ROWS     = ROWS_DEF,
	parameter int COLUMNS  = COLUMNS_DEF,
	parameter int TAB_STOP = TAB_STOP_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  cmd_t      cmd,
	output logic      cmd_pop,
	output logic      init_busy,
	output logic      done,
	output out_item_t result
);

	`include "text_console_char_engine_macros.svh"

	localparam int CELLS     = ROWS * COLUMNS;
	localparam int COPY_LAST = (ROWS - 1) * COLUMNS;
	localparam int AW        = $clog2(CELLS);
	localparam int RW        = $clog2(ROWS);
	localparam int CW        = $clog2(COLUMNS);

	logic [15:0] mem [CELLS];

	state_t        state_q;
	state_t        state_d;
	logic          init_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [AW-1:0] cnt_q;
	logic          sweep_copy_q;
	logic          scrolled_q;
	logic          rd_ok_q;
	logic [15:0]   rd_q;
	logic          cp_vld_s1;
	logic          cp_blank_s1;
	logic [AW-1:0] cp_addr_s1;
	logic          done_q;
	out_item_t     res_q;

	logic [CW-1:0] tab_col [COLUMNS];
	logic          tab_wrap [COLUMNS];

	logic [RW-1:0] nrow;
	logic [CW-1:0] ncol;
	logic          adv;
	logic          clr;
	logic          scr;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] rd_addr_in;
	logic          rd_in_range;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic          emit;
	logic [RW-1:0] rep_row;
	logic [CW-1:0] rep_col;
	out_item_t     res_d;

	for (genvar i = 0; i < COLUMNS; i++) begin : g_tab
		localparam int NXT = ((i + TAB_STOP) / TAB_STOP) * TAB_STOP;
		assign tab_col[i]  = CW'(NXT % COLUMNS);
		assign tab_wrap[i] = (NXT >= COLUMNS);
	end

	assign cur_addr    = AW'(32'(row_q) * COLUMNS + 32'(col_q));
	assign rd_addr_in  = AW'(32'(cmd.read_row) * COLUMNS + 32'(cmd.read_col));
	assign rd_in_range = (32'(cmd.read_row) < ROWS) && (32'(cmd.read_col) < COLUMNS);
	assign init_busy   = init_q;
	assign done        = done_q;
	assign result      = res_q;

	always_comb begin
		nrow = row_q;
		ncol = col_q;
		adv  = 1'b0;
		clr  = 1'b0;
		case (cmd.kind)
			K_BS: begin
				if (col_q != '0) begin
					ncol = col_q - CW'(1);
				end
			end
			K_TAB: begin
				ncol = tab_col[col_q];
				adv  = tab_wrap[col_q];
			end
			K_LF: begin
				ncol = '0;
				adv  = 1'b1;
			end
			K_CR: ncol = '0;
			K_PRINT: begin
				if (col_q == CW'(COLUMNS - 1)) begin
					ncol = '0;
					adv  = 1'b1;
				end else begin
					ncol = col_q + CW'(1);
				end
			end
			K_FF: begin
				nrow = '0;
				ncol = '0;
				clr  = 1'b1;
			end
			default: ncol = col_q;
		endcase
		scr = adv && (row_q == RW'(ROWS - 1));
		if (adv && !scr) begin
			nrow = row_q + RW'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_SWEEP: begin
				if (cnt_q == AW'(CELLS - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: state_d = ST_IDLE;
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.kind == K_READ) begin
						state_d = ST_RDATA;
					end else if (clr || scr) begin
						state_d = ST_SWEEP;
					end
				end
			end
			ST_RDATA: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = rd_addr_in;
		mem_we    = 1'b0;
		mem_waddr = cur_addr;
		mem_wdata = {cmd.color, cmd.char_byte};
		emit      = 1'b0;
		rep_row   = row_q;
		rep_col   = col_q;
		res_d     = '0;
		if (cp_vld_s1) begin
			mem_we    = 1'b1;
			mem_waddr = cp_addr_s1;
			mem_wdata = cp_blank_s1 ? BLANK_CELL : rd_q;
		end
		case (state_q)
			ST_SWEEP: begin
				mem_re    = sweep_copy_q && (32'(cnt_q) < COPY_LAST);
				mem_raddr = cnt_q + AW'(COLUMNS);
			end
			ST_FINISH: begin
				emit = !init_q;
				res_d.scrolled = scrolled_q;
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.kind == K_READ) begin
						mem_re = rd_in_range;
					end else begin
						mem_we  = (cmd.kind == K_PRINT);
						emit    = !(clr || scr);
						rep_row = nrow;
						rep_col = ncol;
					end
				end
			end
			ST_RDATA: begin
				emit = 1'b1;
				if (rd_ok_q) begin
					res_d.cell_char  = rd_q[7:0];
					res_d.cell_color = rd_q[15:8];
				end
			end
			default: emit = 1'b0;
		endcase
		res_d.cursor_row      = 5'(rep_row);
		res_d.cursor_col      = 7'(rep_col);
		res_d.cursor_position = 11'(32'(rep_row) * COLUMNS + 32'(rep_col));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			init_q       <= 1'b1;
			row_q        <= '0;
			col_q        <= '0;
			cnt_q        <= '0;
			sweep_copy_q <= 1'b0;
			cp_vld_s1    <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			state_q   <= state_d;
			done_q    <= emit;
			cp_vld_s1 <= (state_q == ST_SWEEP);
			if (state_q == ST_FINISH) begin
				init_q <= 1'b0;
			end
			if (state_q == ST_SWEEP) begin
				cnt_q <= cnt_q + AW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (cmd_pop && cmd.kind != K_READ) begin
				row_q        <= nrow;
				col_q        <= ncol;
				sweep_copy_q <= scr;
			end
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1  <= cnt_q;
		cp_blank_s1 <= !sweep_copy_q || (32'(cnt_q) >= COPY_LAST);
		res_q       <= res_d;
		if (cmd_pop) begin
			scrolled_q <= scr;
			rd_ok_q    <= rd_in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	`TCCE_ASSERT_IMP(a_no_wb_in_idle, clk, arst_n, state_q == ST_IDLE, !cp_vld_s1, "sweep write pending in idle")
	`TCCE_ASSERT_IMP(a_cursor_range, clk, arst_n, 1'b1, (32'(row_q) < ROWS) && (32'(col_q) < COLUMNS), "cursor out of range")
	`TCCE_ASSERT_NXT(a_finish_to_idle, clk, arst_n, state_q == ST_FINISH, (state_q == ST_IDLE) && !init_q, "finish did not return to idle")
	`TCCE_ASSERT_NXT(a_read_result, clk, arst_n, state_q == ST_RDATA, done_q, "read transaction gave no result")

endmodule

>>> rtl/text_console_char_engine.sv
// Top level of the text console character engine.
`timescale 1ns / 1ps

// Text console engine with a ROWS x COLUMNS screen of character/color cells.
// Input channel: an item is taken at a rising edge with start high and busy low.
// A put item interprets char_byte at the cursor; a read item returns one cell.
// Config channel: cfg_data is written to the text color at cfg_valid & cfg_ready;
// cfg_ready is always high. Write it only while the engine has no work pending.
// Result channel: done is high for one cycle with result valid; the receiver
// cannot stall, and every item gives exactly one result.
// Puts that do not scroll or clear pass the command queue and the result
// register; reads also pass the memory read register. A scroll or a form feed
// sweeps the screen memory once, writing one cell each cycle, a scroll reading
// the cell below to copy. Puts that do not sweep run at one per cycle while no
// sweep is ahead; a read also waits in a read data state before the next item.
// A short command queue lets new items enter while a sweep runs; busy rises
// when it is full. After reset the screen memory is cleared one cell per cycle,
// which keeps busy high until it is done; the cursor is at the top left and the
// color is 0x0F.
module text_console_char_engine
	import tcce_pkg::*;
#(
	parameter int ROWS        = ROWS_DEF,
	parameter int COLUMNS     = COLUMNS_DEF,
	parameter int TAB_STOP    = TAB_STOP_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  in_item_t   item,
	output logic       done,
	output out_item_t  result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic push;
	cmd_t push_cmd;
	logic queue_full;
	logic queue_valid;
	cmd_t head;
	logic pop;
	logic init_busy;

	tcce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.queue_full (queue_full),
		.init_busy  (init_busy),
		.push       (push),
		.cmd        (push_cmd)
	);

	tcce_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.valid    (queue_valid),
		.full     (queue_full),
		.head     (head)
	);

	tcce_back #(
		.ROWS     (ROWS),
		.COLUMNS  (COLUMNS),
		.TAB_STOP (TAB_STOP)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (queue_valid),
		.cmd       (head),
		.cmd_pop   (pop),
		.init_busy (init_busy),
		.done      (done),
		.result    (result)
	);

endmodule
